### design/pff_pkg.sv
// Shared types and constants for the pixel format fan-out block.
// Used by pff_front, pff_cell and pixel_format_fanout_with_palette.
`timescale 1ns / 1ps
`default_nettype none
package pff_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int MAX_WIDTH     = 8192;
    localparam int IDX_W         = 8;
    localparam int COL_W         = $clog2(MAX_WIDTH);
    localparam int CFG_W         = 14;

    localparam logic CFG_IMAGE_WIDTH = 1'b0;
    localparam logic CFG_HAS_ALPHA   = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(1920);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha_in;
    } pix_in_t;

    typedef struct packed {
        logic [31:0] rgba_word;
        logic [7:0]  palette_index;
        logic        palette_overflow;
        logic [7:0]  luma;
        logic        chroma_valid;
        logic [7:0]  chroma_blue;
        logic [7:0]  chroma_red;
    } pix_out_t;

    // Word travelling along the palette chain.
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [31:0]      word;
        logic [7:0]       luma;
        logic             cv;
        logic [7:0]       cb;
        logic [7:0]       cr;
    } chain_t;

    // pos - neg + 0.5, floored, saturated to 0..255.
    function automatic logic [7:0] fix_to_byte(input logic [24:0] pos,
                                               input logic [24:0] neg);
        logic [24:0] p;
        logic [24:0] d;
        p = pos + 25'd32768;
        d = p - neg;
        if (p <= neg)
            return 8'd0;
        else if (d[24:16] > 9'd255)
            return 8'd255;
        else
            return d[23:16];
    endfunction

endpackage
`default_nettype wire

### design/pixel_format_fanout_with_palette.sv
// Top level: entry stage, chain of palette cells and output register.
// Depends on pff_pkg, pff_front and pff_cell.
`timescale 1ns / 1ps
//
// Usage: input words (red, green, blue, alpha_in) arrive on in_valid/in_ready
// in raster order; each produces exactly one result word on out_valid/out_ready.
// A result carries the packed RGBA word, its palette index (or the overflow
// flag), luma and, at even columns of even rows, Cb and Cr.
// A word passes the entry-stage register, then the register in each palette
// cell in turn, then the output register.
// One word per cycle while results are taken; the whole chain advances together.
// When the receiver stalls with a result waiting, the chain freezes and
// in_ready drops until the result is taken.
// Reset empties the palette (every cell's occupied bit cleared), zeroes the
// raster position and sets image_width to 1920 and source_has_alpha to 0.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data, index 0 for
// image_width and 1 for source_has_alpha, while the block is idle.
//
`default_nettype none
module pixel_format_fanout_with_palette (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic                      cfg_index,
    input  wire logic [pff_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire pff_pkg::pix_in_t          in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output pff_pkg::pix_out_t              out_data
);

    pff_pkg::chain_t   chain [pff_pkg::PALETTE_DEPTH+1];
    logic              advance;
    logic              out_valid_reg;
    pff_pkg::pix_out_t out_data_reg;
    pff_pkg::chain_t   tail;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    pff_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .head      (chain[0])
    );

    for (genvar i = 0; i < pff_pkg::PALETTE_DEPTH; i++)
    begin : g_cell
        pff_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .cell_index (pff_pkg::IDX_W'(i)),
            .prev       (chain[i]),
            .next       (chain[i+1])
        );
    end

    assign tail = chain[pff_pkg::PALETTE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= tail.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg.rgba_word        <= tail.word;
            out_data_reg.palette_index    <= tail.found ? tail.idx : '0;
            out_data_reg.palette_overflow <= ~tail.found;
            out_data_reg.luma             <= tail.luma;
            out_data_reg.chroma_valid     <= tail.cv;
            out_data_reg.chroma_blue      <= tail.cb;
            out_data_reg.chroma_red       <= tail.cr;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_ovf_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.palette_overflow |-> out_data.palette_index == '0)
        else $error("overflowed word carries a non-zero index");

    a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.chroma_valid |->
            out_data.chroma_blue == 8'd0 && out_data.chroma_red == 8'd0)
        else $error("chroma set on a word without chroma");

    a_hold_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(tail.valid))
        else $error("chain moved while the output was stalled");

endmodule
`default_nettype wire

### design/pff_front.sv
// Entry stage: packs the word, computes BT.601 Y/Cb/Cr and tracks raster position.
// Depends on pff_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pff_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic                   cfg_index,
    input  wire logic [pff_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                   advance,
    input  wire logic                   in_valid,
    input  wire pff_pkg::pix_in_t       in_data,
    output pff_pkg::chain_t             head
);

    logic [pff_pkg::CFG_W-1:0] width_reg;
    logic                      alpha_reg;
    logic [pff_pkg::COL_W-1:0] col_reg;
    logic [pff_pkg::COL_W-1:0] col_next;
    logic                      row_odd_reg;
    logic                      row_odd_next;
    logic [pff_pkg::CFG_W-1:0] eff_width;
    logic [pff_pkg::CFG_W:0]   col_inc;
    pff_pkg::chain_t           head_reg;
    pff_pkg::chain_t           head_next;
    logic [24:0]               r;
    logic [24:0]               g;
    logic [24:0]               b;

    always_comb
    begin
        r = 25'(in_data.red);
        g = 25'(in_data.green);
        b = 25'(in_data.blue);
        if (width_reg < pff_pkg::CFG_W'(2))
            eff_width = pff_pkg::CFG_W'(2);
        else if (width_reg > pff_pkg::CFG_W'(pff_pkg::MAX_WIDTH))
            eff_width = pff_pkg::CFG_W'(pff_pkg::MAX_WIDTH);
        else
            eff_width = width_reg;
        col_inc      = (pff_pkg::CFG_W+1)'(col_reg) + 1'b1;
        col_next     = col_inc[pff_pkg::COL_W-1:0];
        row_odd_next = row_odd_reg;
        if (col_inc >= (pff_pkg::CFG_W+1)'(eff_width))
        begin
            col_next     = '0;
            row_odd_next = ~row_odd_reg;
        end

        head_next.valid = in_valid;
        head_next.found = 1'b0;
        head_next.idx   = '0;
        head_next.word  = {alpha_reg ? in_data.alpha_in : 8'hFF,
                           in_data.blue, in_data.green, in_data.red};
        head_next.luma  = pff_pkg::fix_to_byte(25'd19595 * r + 25'd38470 * g
                                               + 25'd7471 * b, 25'd0);
        head_next.cv    = ~col_reg[0] & ~row_odd_reg;
        head_next.cb    = 8'd0;
        head_next.cr    = 8'd0;
        if (head_next.cv)
        begin
            head_next.cb = pff_pkg::fix_to_byte(25'(128 << 16) + 25'd32768 * b,
                                                25'd11058 * r + 25'd21710 * g);
            head_next.cr = pff_pkg::fix_to_byte(25'(128 << 16) + 25'd32768 * r,
                                                25'd27439 * g + 25'd5329 * b);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= pff_pkg::WIDTH_RESET;
            alpha_reg   <= 1'b0;
            col_reg     <= '0;
            row_odd_reg <= 1'b0;
            head_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == pff_pkg::CFG_IMAGE_WIDTH)
                    width_reg <= cfg_data;
                else
                    alpha_reg <= cfg_data[0];
            end
            if (advance)
            begin
                head_reg <= head_next;
                if (in_valid)
                begin
                    col_reg     <= col_next;
                    row_odd_reg <= row_odd_next;
                end
            end
        end
    end

    assign head = head_reg;

endmodule
`default_nettype wire

### design/pff_cell.sv
// One palette cell: holds one entry, matches or claims it, and passes the word on.
// Depends on pff_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pff_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      advance,
    input  wire logic [pff_pkg::IDX_W-1:0] cell_index,
    input  wire pff_pkg::chain_t           prev,
    output pff_pkg::chain_t                next
);

    logic            occ_reg;
    logic            occ_next;
    logic [31:0]     entry_reg;
    pff_pkg::chain_t stage_reg;
    pff_pkg::chain_t stage_next;

    // Words reach a cell in arrival order, so the first unmatched word to find
    // an empty cell takes it, just as the palette is appended in order.
    always_comb
    begin
        stage_next = prev;
        occ_next   = occ_reg;
        if (prev.valid && !prev.found)
        begin
            if (occ_reg && entry_reg == prev.word)
            begin
                stage_next.found = 1'b1;
                stage_next.idx   = cell_index;
            end
            else if (!occ_reg)
            begin
                occ_next         = 1'b1;
                stage_next.found = 1'b1;
                stage_next.idx   = cell_index;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= 1'b0;
            stage_reg <= '0;
        end
        else if (advance)
        begin
            occ_reg   <= occ_next;
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && !occ_reg && occ_next)
            entry_reg <= prev.word;
    end

    assign next = stage_reg;

endmodule
`default_nettype wire

### tb/sv/tb.sv
// Testbench for pixel_format_fanout_with_palette: drives pixels, predicts each result word
// with a local palette and BT.601 model held in a scoreboard class. Depends on pff_pkg.
`timescale 1ns / 1ps
module tb;

    localparam int QUIET_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 300;

    class pixel_scoreboard;
        logic [31:0] entries[pff_pkg::PALETTE_DEPTH];
        int unsigned count;
        int unsigned column;
        bit row_odd;
        int unsigned width_reg;
        bit has_alpha;
        pff_pkg::pix_out_t expected_q[$];
        int mismatches;

        function void clear();
            count = 0;
            column = 0;
            row_odd = 0;
            width_reg = 1920;
            has_alpha = 0;
            mismatches = 0;
        endfunction

        function logic [7:0] to_byte(longint pos, longint neg);
            longint v;
            pos += 32768;
            if (pos <= neg)
                return 8'd0;
            v = (pos - neg) >>> 16;
            return (v > 255) ? 8'd255 : v[7:0];
        endfunction

        function void note_pixel(pff_pkg::pix_in_t p);
            pff_pkg::pix_out_t e;
            longint r;
            longint g;
            longint b;
            int unsigned w;
            bit found;
            r = p.red;
            g = p.green;
            b = p.blue;
            found = 0;
            e = '0;
            e.rgba_word = {has_alpha ? p.alpha_in : 8'hFF, p.blue, p.green, p.red};
            for (int i = 0; i < count; i++)
            begin
                if (!found && entries[i] == e.rgba_word)
                begin
                    e.palette_index = 8'(i);
                    found = 1;
                end
            end
            if (!found)
            begin
                if (count < pff_pkg::PALETTE_DEPTH)
                begin
                    entries[count] = e.rgba_word;
                    e.palette_index = 8'(count);
                    count++;
                end
                else
                    e.palette_overflow = 1;
            end
            e.luma = to_byte(19595 * r + 38470 * g + 7471 * b, 0);
            e.chroma_valid = (column % 2 == 0) && !row_odd;
            if (e.chroma_valid)
            begin
                e.chroma_blue = to_byte((128 << 16) + 32768 * b, 11058 * r + 21710 * g);
                e.chroma_red = to_byte((128 << 16) + 32768 * r, 27439 * g + 5329 * b);
            end
            column++;
            w = width_reg < 2 ? 2 : (width_reg > pff_pkg::MAX_WIDTH ? pff_pkg::MAX_WIDTH
                                                                     : width_reg);
            if (column >= w)
            begin
                column = 0;
                row_odd = !row_odd;
            end
            expected_q = {expected_q, e};
        endfunction

        function void check_result(pff_pkg::pix_out_t got);
            pff_pkg::pix_out_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word %h", got);
                return;
            end
            e = expected_q.pop_front();
            if (got !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %h, got %h", e, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_index;
    logic [pff_pkg::CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    pff_pkg::pix_in_t in_data;
    logic out_valid;
    logic out_ready;
    pff_pkg::pix_out_t out_data;

    pixel_scoreboard sb;
    bit hold_off;
    bit calm;
    int quiet_cycles = 0;

    pixel_format_fanout_with_palette dut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    task automatic write_reg(logic idx, int unsigned value);
        @(negedge clk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data <= pff_pkg::CFG_W'(value);
        if (idx == pff_pkg::CFG_IMAGE_WIDTH)
            sb.width_reg = value;
        else
            sb.has_alpha = value[0];
        @(negedge clk);
        cfg_wr_en <= 0;
    endtask

    // Offers one word, with an occasional idle gap first. Valid stays high
    // after acceptance so that words can follow back to back.
    task automatic send_pixel(pff_pkg::pix_in_t p);
        if (!calm && $urandom_range(99) < 6)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        in_data <= p;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_pixel(p);
        @(negedge clk);
    endtask

    task automatic send_random(int n, int colours);
        pff_pkg::pix_in_t p;
        for (int i = 0; i < n; i++)
        begin
            p = pff_pkg::pix_in_t'($urandom);
            // A small colour set gives palette hits; otherwise colours are fresh.
            if (colours > 0)
                p = {8'($urandom_range(colours)), 8'(3 * $urandom_range(colours)),
                     8'hA5, 8'($urandom_range(1))};
            send_pixel(p);
        end
    endtask

    task automatic settle();
        in_valid <= 0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_result(out_data);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stalls, a calm stretch and one long hold-off.
    initial
    begin
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ready <= 0;
                repeat (600) @(negedge clk);
                hold_off = 0;
            end
            out_ready <= calm || $urandom_range(99) >= 6;
        end
    end

    initial
    begin
        sb = new();
        sb.clear();
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_index = pff_pkg::CFG_IMAGE_WIDTH;
        cfg_data = '0;
        in_valid = 0;
        in_data = '0;
        hold_off = 0;
        calm = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: extremes and chroma corners, narrow width for parity.
        write_reg(pff_pkg::CFG_IMAGE_WIDTH, 2);
        write_reg(pff_pkg::CFG_HAS_ALPHA, 1);
        send_pixel('0);
        send_pixel('1);
        send_pixel({8'hFF, 8'h00, 8'h00, 8'h80});
        send_pixel({8'h00, 8'hFF, 8'h00, 8'h7F});
        send_pixel({8'h00, 8'h00, 8'hFF, 8'h01});
        send_pixel({8'hFF, 8'h00, 8'h00, 8'h80});
        send_pixel({8'h00, 8'hFF, 8'hFF, 8'hFE});
        send_pixel({8'hFF, 8'hFF, 8'h00, 8'h55});
        send_pixel({8'hAA, 8'h55, 8'hAA, 8'hAA});
        send_pixel('1);
        settle();

        // Out-of-range widths are clamped; odd widths flip parity unevenly.
        write_reg(pff_pkg::CFG_IMAGE_WIDTH, 0);
        write_reg(pff_pkg::CFG_HAS_ALPHA, 0);
        send_random(6, 0);
        settle();
        write_reg(pff_pkg::CFG_IMAGE_WIDTH, 16383);
        send_random(20, 4);
        settle();
        write_reg(pff_pkg::CFG_IMAGE_WIDTH, 7);
        send_random(150, 0);
        settle();

        // Fill pressure: the receiver holds off while the sender keeps going.
        hold_off = 1;
        write_reg(pff_pkg::CFG_IMAGE_WIDTH, 8192);
        send_random(400, 0);
        settle();

        // The palette is full now: mostly overflow with a few old hits.
        calm = 1;
        write_reg(pff_pkg::CFG_IMAGE_WIDTH, 1);
        write_reg(pff_pkg::CFG_HAS_ALPHA, 1);
        send_random(400, 0);
        calm = 0;
        settle();
        write_reg(pff_pkg::CFG_IMAGE_WIDTH, 2 * $urandom_range(1, 20));
        write_reg(pff_pkg::CFG_HAS_ALPHA, 0);
        send_random(450, 9);
        settle();
        write_reg(pff_pkg::CFG_IMAGE_WIDTH, 1920);
        write_reg(pff_pkg::CFG_HAS_ALPHA, 1);
        send_random(480, 0);
        settle();

        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

### pixel_format_fanout_with_palette.f
design/pff_pkg.sv
design/pff_front.sv
design/pff_cell.sv
design/pixel_format_fanout_with_palette.sv
tb/sv/tb.sv
